// ===== hdl/ttlb_pkg.sv =====
`default_nettype none
// ============================================================================
// ttlb_pkg: shared types and constants of the text terminal line buffer
// Geometry of the line store, control byte codes and the structs passed
// between the core and its storage block.
// ============================================================================
package ttlb_pkg;

    localparam int MAX_LINES    = 64;
    localparam int MAX_LINE_LEN = 128;

    localparam int ROW_W    = $clog2(MAX_LINES);
    localparam int COL_W    = $clog2(MAX_LINE_LEN);
    localparam int LCOUNT_W = $clog2(MAX_LINES + 1);
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int DEPTH    = MAX_LINES * MAX_LINE_LEN;

    localparam logic [7:0] C_BS    = 8'h08;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_ESC   = 8'h1B;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_AT    = 8'h40;
    localparam logic [7:0] C_TILDE = 8'h7E;
    localparam logic [7:0] C_DEL   = 8'h7F;

    localparam logic KIND_FEED = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic              char_we;
        logic [ADDR_W-1:0] char_addr;
        logic [7:0]        char_data;
        logic              len_we;
        logic [ROW_W-1:0]  len_row;
        logic [COL_W-1:0]  len_data;
    } t_store_wr;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_store_rd;

    typedef struct packed {
        logic [7:0]       chr;
        logic [COL_W-1:0] len;
        logic             len_vld;
    } t_store_rsp;

endpackage
`default_nettype wire

// ===== hdl/ttlb_store.sv =====
`default_nettype none
// ============================================================================
// ttlb_store: character store and row length store
// One write and one registered read per cycle on each memory. Row lengths
// carry a valid bit per row so that an unwritten row reads as empty.
// ============================================================================
module ttlb_store
    import ttlb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_store_wr  i_wr,
    input  wire t_store_rd  i_rd,
    output t_store_rsp      o_rsp
);

    logic [7:0]       r_chars [DEPTH];
    logic [COL_W-1:0] r_lens  [MAX_LINES];
    logic [MAX_LINES-1:0] r_len_vld;

    logic [7:0]       r_chr_q;
    logic [COL_W-1:0] r_len_q;
    logic             r_len_vld_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.char_we) begin
            r_chars[i_wr.char_addr] <= i_wr.char_data;
        end
        if (i_rd.en) begin
            r_chr_q <= r_chars[{i_rd.row, i_rd.col}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.len_we) begin
            r_lens[i_wr.len_row] <= i_wr.len_data;
        end
        if (i_rd.en) begin
            r_len_q <= r_lens[i_rd.row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld   <= '0;
            r_len_vld_q <= 1'b0;
        end else begin
            if (i_wr.len_we) begin
                r_len_vld[i_wr.len_row] <= 1'b1;
            end
            if (i_rd.en) begin
                r_len_vld_q <= r_len_vld[i_rd.row];
            end
        end
    end

    assign o_rsp.chr     = r_chr_q;
    assign o_rsp.len     = r_len_q;
    assign o_rsp.len_vld = r_len_vld_q;

endmodule
`default_nettype wire

// ===== hdl/text_terminal_line_buffer_core.sv =====
`default_nettype none
// ============================================================================
// text_terminal_line_buffer_core: scrolling text line store for a terminal
// Interprets terminal output bytes into lines and answers character reads.
// ============================================================================
// Items, feeds or reads, stream at one per clock while the stage register
// can move on; a TAB holds off the next item while its second space goes
// as a second write through the single write port of the character store.
// The result of an item passes the stage register and then the output
// register; a result waiting there stops the next item only once the stage
// register is full as well. The character store needs no clearing after
// reset: row lengths carry valid bits, so items are taken right after reset.
module text_terminal_line_buffer_core
    import ttlb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // data_byte[7:0], start_of_buffer[8], read_row[14:9], read_col[21:15]
    input  wire logic [23:0] i_s_axis_tdata,
    // kind[0]
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // read_char[7:0], line_count[14:8], current_length[21:15], scrolled[22]
    output logic [23:0]      o_m_axis_tdata
);

    logic [7:0]       in_byte;
    logic             in_sob;
    logic [5:0]       in_row;
    logic [6:0]       in_col;
    logic             in_kind;

    assign in_byte = i_s_axis_tdata[7:0];
    assign in_sob  = i_s_axis_tdata[8];
    assign in_row  = i_s_axis_tdata[14:9];
    assign in_col  = i_s_axis_tdata[21:15];
    assign in_kind = i_s_axis_tuser;

    logic [ROW_W-1:0]    r_base,    n_base;
    logic [ROW_W-1:0]    r_cur_row, n_cur_row;
    logic [COL_W-1:0]    r_cur_len, n_cur_len;
    logic [LCOUNT_W-1:0] r_lines,   n_lines;
    logic                r_esc,     n_esc;
    logic                r_tab,     n_tab;
    logic                r_tab_scr, n_tab_scr;

    logic                r_s1_vld;
    logic                r_s1_kind;
    logic                r_s1_row_ok;
    logic [COL_W-1:0]    r_s1_col;
    logic [LCOUNT_W-1:0] r_s1_lines;
    logic [COL_W-1:0]    r_s1_len;
    logic                r_s1_scr;

    logic                r_out_vld;
    logic [23:0]         r_out_data;

    logic       acc;
    logic       s1_adv;
    logic       s1_load;
    logic       esc_eff;
    logic       tab_start;
    logic       scr;

    t_store_wr  st_wr;
    t_store_rd  st_rd;
    t_store_rsp st_rsp;

    // Shared open-line and put-character step on the current registers.
    logic [ROW_W-1:0]    row_inc;
    logic [ROW_W-1:0]    base_inc;
    logic                full;
    logic [ROW_W-1:0]    op_row;
    logic [ROW_W-1:0]    op_base;
    logic [LCOUNT_W-1:0] op_lines;
    logic                wrap;
    logic [ROW_W-1:0]    p_row;
    logic [ROW_W-1:0]    p_base;
    logic [LCOUNT_W-1:0] p_lines;
    logic [COL_W-1:0]    p_pos;
    logic                p_scr;
    logic [7:0]          p_char;

    logic [ROW_W:0]      rd_sum;
    logic [ROW_W-1:0]    rd_phys;
    logic                rd_row_ok;
    logic                s1_hit;
    logic [7:0]          s1_char;

    assign s1_adv          = r_s1_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_tab && (!r_s1_vld || s1_adv);
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;

    assign esc_eff   = r_esc && !(acc && in_sob);
    assign tab_start = acc && (in_kind == KIND_FEED) && !esc_eff && (in_byte == C_TAB);
    assign s1_load   = (acc && !tab_start) || r_tab;

    always_comb begin
        row_inc  = (r_cur_row == ROW_W'(MAX_LINES - 1)) ? '0 : r_cur_row + 1'b1;
        base_inc = (r_base == ROW_W'(MAX_LINES - 1)) ? '0 : r_base + 1'b1;
        full     = (r_lines == LCOUNT_W'(MAX_LINES));
        // The current row always steps on; a full store also moves its base.
        op_row   = row_inc;
        op_base  = full ? base_inc : r_base;
        op_lines = full ? r_lines : r_lines + 1'b1;

        wrap    = (r_cur_len >= COL_W'(MAX_LINE_LEN - 1));
        p_row   = wrap ? op_row   : r_cur_row;
        p_base  = wrap ? op_base  : r_base;
        p_lines = wrap ? op_lines : r_lines;
        p_pos   = wrap ? '0       : r_cur_len;
        p_scr   = wrap && full;
        p_char  = (r_tab || tab_start) ? C_SPACE : in_byte;
    end

    // Next state
    always_comb begin
        n_base    = r_base;
        n_cur_row = r_cur_row;
        n_cur_len = r_cur_len;
        n_lines   = r_lines;
        n_esc     = esc_eff;
        n_tab     = 1'b0;
        n_tab_scr = r_tab_scr;
        scr       = 1'b0;
        st_wr     = '0;

        if (r_tab) begin
            n_base    = p_base;
            n_cur_row = p_row;
            n_lines   = p_lines;
            n_cur_len = p_pos + 1'b1;
            scr       = r_tab_scr || p_scr;
            st_wr.char_we = 1'b1;
        end else if (acc && (in_kind == KIND_FEED)) begin
            if (esc_eff) begin
                if (in_byte >= C_AT && in_byte <= C_TILDE) begin
                    n_esc = 1'b0;
                end
            end else if (in_byte == C_ESC) begin
                n_esc = 1'b1;
            end else if (in_byte == C_CR) begin
                n_cur_len = '0;
            end else if (in_byte == C_LF) begin
                n_base    = op_base;
                n_cur_row = op_row;
                n_lines   = op_lines;
                n_cur_len = '0;
                scr       = full;
            end else if (in_byte == C_BS || in_byte == C_DEL) begin
                if (r_cur_len != '0) begin
                    n_cur_len = r_cur_len - 1'b1;
                end
            end else if (in_byte == C_TAB) begin
                n_base    = p_base;
                n_cur_row = p_row;
                n_lines   = p_lines;
                n_cur_len = p_pos + 1'b1;
                n_tab     = 1'b1;
                n_tab_scr = p_scr;
                st_wr.char_we = 1'b1;
            end else if (in_byte >= C_SPACE && in_byte <= C_TILDE) begin
                n_base    = p_base;
                n_cur_row = p_row;
                n_lines   = p_lines;
                n_cur_len = p_pos + 1'b1;
                scr       = p_scr;
                st_wr.char_we = 1'b1;
            end
        end

        st_wr.char_addr = {p_row, p_pos};
        st_wr.char_data = p_char;
        // The length store follows the current row on every feed step.
        st_wr.len_we    = r_tab || (acc && (in_kind == KIND_FEED));
        st_wr.len_row   = n_cur_row;
        st_wr.len_data  = n_cur_len;
    end

    // Read request
    always_comb begin
        rd_sum    = {1'b0, r_base} + (ROW_W + 1)'(in_row);
        rd_phys   = (rd_sum >= (ROW_W + 1)'(MAX_LINES)) ?
                    ROW_W'(rd_sum - (ROW_W + 1)'(MAX_LINES)) : rd_sum[ROW_W-1:0];
        rd_row_ok = (LCOUNT_W'(in_row) < r_lines);
        st_rd.en  = acc && (in_kind == KIND_READ);
        st_rd.row = rd_phys;
        st_rd.col = COL_W'(in_col);
    end

    ttlb_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (st_wr),
        .i_rd    (st_rd),
        .o_rsp   (st_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_cur_row <= '0;
            r_cur_len <= '0;
            r_lines   <= LCOUNT_W'(1);
            r_esc     <= 1'b0;
            r_tab     <= 1'b0;
            r_tab_scr <= 1'b0;
        end else begin
            r_base    <= n_base;
            r_cur_row <= n_cur_row;
            r_cur_len <= n_cur_len;
            r_lines   <= n_lines;
            r_esc     <= n_esc;
            r_tab     <= n_tab;
            r_tab_scr <= n_tab_scr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_load) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_kind   <= r_tab ? KIND_FEED : in_kind;
            r_s1_row_ok <= rd_row_ok;
            r_s1_col    <= COL_W'(in_col);
            r_s1_lines  <= n_lines;
            r_s1_len    <= n_cur_len;
            r_s1_scr    <= scr;
        end
    end

    // Read data arrives from the store together with the stage register.
    assign s1_hit  = (r_s1_kind == KIND_READ) && r_s1_row_ok && st_rsp.len_vld &&
                     (r_s1_col < st_rsp.len);
    assign s1_char = s1_hit ? st_rsp.chr : 8'h00;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= {1'b0, r_s1_scr, r_s1_len, r_s1_lines, s1_char};
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    a_lines_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lines >= LCOUNT_W'(1)) && (r_lines <= LCOUNT_W'(MAX_LINES)))
        else $error("line count out of range");

    a_cur_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_row == ROW_W'(((ROW_W + 1)'(r_base) + (ROW_W + 1)'(r_lines) - 1'b1)
                            % MAX_LINES))
        else $error("current row does not follow base and line count");

    a_tab_stage_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tab |-> !r_s1_vld)
        else $error("second tab step found the stage register occupied");

    a_tab_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tab |=> !r_tab)
        else $error("tab step lasted more than one extra cycle");

endmodule
`default_nettype wire

// ===== tb/tb_text_terminal_line_buffer_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_text_terminal_line_buffer_core: regression bench for the line buffer core
// Feeds terminal byte streams and character reads through the input stream,
// predicts every result with a local model of the line store and checks each
// returned item field by field, with random gaps and stalls on both sides.
// ============================================================================
module tb_text_terminal_line_buffer_core
    import ttlb_pkg::*;
();

    // Scoreboard: mirrors the line store and queues the expected result items.
    class text_line_scoreboard;
        logic [7:0]       line_chars [DEPTH];
        int               line_len [MAX_LINES];
        int               top_row;
        int               held;
        bit               skipping_escape;
        logic [23:0]      pending_results [$];
        int               errors;
        int               checked;
        int               feeds;
        int               reads;
        int               scrolls;
        int               wraps;

        function new();
            foreach (line_len[i]) line_len[i] = 0;
            top_row = 0;
            held = 1;
            skipping_escape = 1'b0;
        endfunction

        function int phys_row(int logical);
            return (top_row + (logical % MAX_LINES)) % MAX_LINES;
        endfunction

        // Opens a new last line; returns 1 when the oldest line is dropped.
        function bit open_line();
            if (held < MAX_LINES) begin
                held++;
                line_len[phys_row(held - 1)] = 0;
                return 1'b0;
            end
            top_row = (top_row + 1) % MAX_LINES;
            line_len[phys_row(held - 1)] = 0;
            scrolls++;
            return 1'b1;
        endfunction

        function bit append_char(logic [7:0] c);
            bit dropped;
            int row;
            dropped = 1'b0;
            row = phys_row(held - 1);
            if (line_len[row] >= MAX_LINE_LEN - 1) begin
                dropped = open_line();
                row = phys_row(held - 1);
                wraps++;
            end
            line_chars[row * MAX_LINE_LEN + line_len[row]] = c;
            line_len[row]++;
            return dropped;
        endfunction

        function void note_item(logic kind, logic [23:0] d);
            logic [7:0] b;
            logic [7:0] rchar;
            int         row;
            bit         scrolled;
            b = d[7:0];
            rchar = 8'h00;
            scrolled = 1'b0;
            if (d[8]) skipping_escape = 1'b0;
            if (kind == KIND_READ) begin
                reads++;
                if (int'(d[14:9]) < held) begin
                    row = phys_row(int'(d[14:9]));
                    if (int'(d[21:15]) < line_len[row])
                        rchar = line_chars[row * MAX_LINE_LEN + int'(d[21:15])];
                end
            end else begin
                feeds++;
                row = phys_row(held - 1);
                if (skipping_escape) begin
                    if (b >= C_AT && b <= C_TILDE) skipping_escape = 1'b0;
                end else if (b == C_ESC) begin
                    skipping_escape = 1'b1;
                end else if (b == C_CR) begin
                    line_len[row] = 0;
                end else if (b == C_LF) begin
                    scrolled = open_line();
                end else if (b == C_BS || b == C_DEL) begin
                    if (line_len[row] > 0) line_len[row]--;
                end else if (b == C_TAB) begin
                    scrolled = append_char(C_SPACE);
                    scrolled = append_char(C_SPACE) | scrolled;
                end else if (b >= C_SPACE && b <= C_TILDE) begin
                    scrolled = append_char(b);
                end
            end
            pending_results.push_back({1'b0, scrolled, 7'(line_len[phys_row(held - 1)]),
                                       7'(held), rchar});
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= 40)
                    $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(logic [23:0] got);
            logic [23:0] want;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, got);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            compare_field("read_char", want[7:0], got[7:0]);
            compare_field("line_count", {1'b0, want[14:8]}, {1'b0, got[14:8]});
            compare_field("current_length", {1'b0, want[21:15]}, {1'b0, got[21:15]});
            compare_field("scrolled", {7'd0, want[22]}, {7'd0, got[22]});
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;

    text_line_scoreboard sb = new();
    int burst_left = 0;
    int sent = 0;

    text_terminal_line_buffer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Inputs are noted before outputs are checked, so ordering within a step is fixed.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_item(i_s_axis_tuser, i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata);
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off once results flow.
    initial begin : receiver
        int  mode;
        int  mode_left;
        int  hold;
        int  cyc;
        bit  held_off;
        mode = 0;
        mode_left = 0;
        hold = 0;
        cyc = 0;
        held_off = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (!held_off && sb.checked >= 300) begin
                held_off = 1'b1;
                hold = 250;
            end
            if (hold > 0) begin
                hold--;
                i_m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0: i_m_axis_tready <= 1'b1;
                    1: i_m_axis_tready <= 1'($urandom_range(0, 1));
                    2: i_m_axis_tready <= ($urandom_range(0, 9) != 0);
                    default: i_m_axis_tready <= (cyc % 4 != 0);
                endcase
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input logic kind, input logic [23:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= data;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_feed(input logic [7:0] b, input logic sob = 1'b0);
        send_item(KIND_FEED, {2'b00, 7'($urandom), 6'($urandom), sob, b});
    endtask

    task automatic send_read(input logic [5:0] row, input logic [6:0] col,
                             input logic sob = 1'b0);
        send_item(KIND_READ, {2'b00, col, row, sob, 8'($urandom)});
    endtask

    function automatic logic random_sob();
        return ($urandom_range(0, 19) == 0);
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(C_SPACE, C_TILDE));
    endfunction

    // Escape sequence with parameter bytes; sometimes cut short by a start mark.
    task automatic send_escape();
        int n;
        n = $urandom_range(0, 3);
        send_feed(C_ESC, random_sob());
        repeat (n) send_feed(8'($urandom_range(8'h20, 8'h3F)));
        if ($urandom_range(0, 4) == 0)
            send_feed(printable(), 1'b1);
        else
            send_feed(8'($urandom_range(C_AT, C_TILDE)));
    endtask

    task automatic send_reads();
        int n;
        int row;
        int col;
        n = $urandom_range(0, 3);
        repeat (n) begin
            row = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                              : $urandom_range(0, sb.held - 1);
            col = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                              : $urandom_range(0, 24);
            send_read(6'(row), 7'(col), random_sob());
        end
    endtask

    task automatic send_short_line();
        int n;
        int pick;
        n = $urandom_range(0, 8);
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 78)      send_feed(printable(), random_sob());
            else if (pick < 84) send_feed(C_TAB);
            else if (pick < 88) send_feed(($urandom_range(0, 1) != 0) ? C_BS : C_DEL);
            else if (pick < 90) send_feed(C_CR);
            else if (pick < 96) send_escape();
            else                send_feed(8'($urandom), random_sob());
        end
        if ($urandom_range(0, 9) < 8) send_feed(C_LF);
    endtask

    // A line usually long enough to wrap, closed by a tab so either space may wrap.
    task automatic send_long_line();
        int n;
        n = $urandom_range(124, 134);
        repeat (n) send_feed(printable());
        send_feed(C_TAB);
        send_feed(C_LF);
    endtask

    initial begin : main
        int pick;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening.
        send_read(6'd0, 7'd0);
        send_feed(8'h41, 1'b1);
        send_feed(C_TILDE);
        send_feed(C_SPACE);
        send_feed(C_TAB);
        send_feed(C_BS);
        send_feed(C_DEL);
        send_read(6'd0, 7'd0);
        send_read(6'd63, 7'd127);
        send_feed(C_ESC);
        send_feed(8'h31);
        send_feed(8'h3F);
        send_feed(8'h6D);
        send_feed(C_ESC);
        send_read(6'd0, 7'd1, 1'b1);
        send_feed(8'h42);
        send_feed(8'h00);
        send_feed(8'hFF);
        send_feed(8'h80);
        send_feed(C_CR);
        send_feed(C_BS);
        send_feed(C_LF);
        send_feed(8'h43);
        send_read(6'd1, 7'd0);
        send_read(6'd0, 7'd127);

        // Random part: mostly well-formed text lines, some long ones and bare line feeds.
        while (sent < 790) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)       send_long_line();
            else if (pick < 15) repeat ($urandom_range(3, 8)) send_feed(C_LF);
            else                send_short_line();
            send_reads();
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.pending_results.size() != 0) sb.errors++;

        $display("Covered %0d items: %0d feeds and %0d reads, %0d results checked.",
                 sent, sb.feeds, sb.reads, sb.checked);
        $display("The store scrolled %0d times and wrapped long lines %0d times.",
                 sb.scrolls, sb.wraps);
        if (sb.errors == 0)
            $display("text_terminal_line_buffer_core regression: pass");
        else
            $display("text_terminal_line_buffer_core regression: fail");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("text_terminal_line_buffer_core regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ttlb_pkg.sv
hdl/ttlb_store.sv
hdl/text_terminal_line_buffer_core.sv
tb/tb_text_terminal_line_buffer_core.sv
